// ----- sv/evr_pkg.sv -----
// evr_pkg: shared widths, constants, payload types and CORDIC angle table
// for the Euler XYZ vector rotator. No dependencies.
`timescale 1ns / 1ps
package evr_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int ANGLE_WIDTH    = 16;
    localparam int ROTATION_STEPS = 16;
    localparam int GUARD_BITS     = 10;
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    // internal coordinate width: guard bits plus headroom for CORDIC growth
    localparam int INT_WIDTH = (COORD_WIDTH + GUARD_BITS + 4 > 34) ?
                               (COORD_WIDTH + GUARD_BITS + 4) : 34;
    // residual angle: 32-bit turn plus sign and growth
    localparam int RES_WIDTH = 34;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
        logic [ANGLE_WIDTH-1:0]        angle_x;
        logic [ANGLE_WIDTH-1:0]        angle_y;
        logic [ANGLE_WIDTH-1:0]        angle_z;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
    } result_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] t;
        case (i)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2FA;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            23: t = 32'h00000051;
            24: t = 32'h00000029;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000003;
            29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ----- sv/evr_rotate_pair.sv -----
// evr_rotate_pair: pipelined plane rotation of (a, b) by a binary angle:
// quadrant fold, one CORDIC stage per step, three-stage gain. Uses evr_pkg.
`timescale 1ns / 1ps
module evr_rotate_pair #(
    parameter int ROTATION_STEPS = evr_pkg::ROTATION_STEPS,
    parameter int SIDE_WIDTH     = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [evr_pkg::INT_WIDTH-1:0] in_a,
    input  logic signed [evr_pkg::INT_WIDTH-1:0] in_b,
    input  logic [evr_pkg::ANGLE_WIDTH-1:0]      in_angle,
    input  logic [SIDE_WIDTH-1:0]                in_side,
    output logic                                 out_valid,
    output logic signed [evr_pkg::INT_WIDTH-1:0] out_a,
    output logic signed [evr_pkg::INT_WIDTH-1:0] out_b,
    output logic [SIDE_WIDTH-1:0]                out_side
);
    localparam int IW    = evr_pkg::INT_WIDTH;
    localparam int RW    = evr_pkg::RES_WIDTH;
    localparam int DEPTH = ROTATION_STEPS + 4; // fold + steps + gain

    // valid and sideband delay line across all stages
    logic                  vld_reg  [DEPTH];
    logic [SIDE_WIDTH-1:0] side_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < DEPTH; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // quadrant fold
    logic signed [IW-1:0] p_reg [ROTATION_STEPS+1];
    logic signed [IW-1:0] q_reg [ROTATION_STEPS+1];
    logic signed [RW-1:0] r_reg [ROTATION_STEPS+1];
    logic [31:0]          u_turn;
    logic                 fold;

    assign u_turn = {in_angle, {(32 - evr_pkg::ANGLE_WIDTH){1'b0}}};
    assign fold   = u_turn[31] ^ u_turn[30];

    always_ff @(posedge clk)
    begin
        p_reg[0] <= fold ? -in_a : in_a;
        q_reg[0] <= fold ? -in_b : in_b;
        r_reg[0] <= RW'(signed'({u_turn[31] ^ fold, u_turn[30:0]}));
    end

    // CORDIC stages
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_step
        localparam logic [RW-1:0] T = RW'(evr_pkg::atan_turn(i));
        logic signed [IW-1:0] ps;
        logic signed [IW-1:0] qs;
        assign ps = p_reg[i] >>> i;
        assign qs = q_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (!r_reg[i][RW-1])
            begin
                p_reg[i+1] <= p_reg[i] - qs;
                q_reg[i+1] <= q_reg[i] + ps;
                r_reg[i+1] <= r_reg[i] - signed'(T);
            end
            else
            begin
                p_reg[i+1] <= p_reg[i] + qs;
                q_reg[i+1] <= q_reg[i] - ps;
                r_reg[i+1] <= r_reg[i] + signed'(T);
            end
        end
    end

    // gain: magnitude times GAIN_Q32 / 2^32, rounded half up, sign restored
    logic signed [IW-1:0] gin [2];
    logic signed [IW-1:0] gout_reg [2];
    assign gin[0] = p_reg[ROTATION_STEPS];
    assign gin[1] = q_reg[ROTATION_STEPS];

    for (genvar j = 0; j < 2; j++)
    begin : g_gain
        logic          neg1_reg;
        logic          neg2_reg;
        logic [IW-1:0] mag_reg;
        logic [63:0]   lo_prod_reg;
        logic [IW-1:0] hi_prod_reg;
        logic [32:0]   lo_round;
        logic [IW-1:0] mag_out;

        assign lo_round = 33'((65'(lo_prod_reg) + 65'h80000000) >> 32);
        assign mag_out  = hi_prod_reg + IW'(lo_round);

        always_ff @(posedge clk)
        begin
            neg1_reg    <= gin[j][IW-1];
            mag_reg     <= gin[j][IW-1] ? IW'(-gin[j]) : IW'(gin[j]);
            neg2_reg    <= neg1_reg;
            lo_prod_reg <= 64'(mag_reg[31:0]) * 64'(evr_pkg::GAIN_Q32);
            hi_prod_reg <= IW'(IW'(mag_reg[IW-1:32]) * IW'(evr_pkg::GAIN_Q32));
            gout_reg[j] <= neg2_reg ? -signed'(mag_out) : signed'(mag_out);
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_a     = gout_reg[0];
    assign out_b     = gout_reg[1];
    assign out_side  = side_reg[DEPTH-1];

endmodule

// ----- sv/euler_xyz_vector_rotator.sv -----
// euler_xyz_vector_rotator: top level, turns a Q16.16 vector about X, Y, Z.
// Depends on evr_pkg and evr_rotate_pair.
`timescale 1ns / 1ps
// Usage:
//   A beat is offered on cmd with start high; it is taken at any rising edge
//   where start is high and busy is low. busy is always low: the pipeline
//   takes one beat in every cycle.
//   Each beat gives one result beat on result, marked by done for exactly one
//   cycle. The receiver cannot stall, so nothing is held back; results leave
//   in the order their commands arrived.
//   Each rotation is a fold stage, one stage per CORDIC step and a three-stage
//   gain multiply; one more stage rounds and saturates.
//   Throughput: one beat per cycle, fixed by the fully pipelined CORDIC.
//   Reset (rst_n low, asynchronous) clears all valid bits, so no stray done
//   appears; data in flight is dropped.
module euler_xyz_vector_rotator #(
    parameter int ROTATION_STEPS = evr_pkg::ROTATION_STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  evr_pkg::cmd_t    cmd,
    output logic             done,
    output evr_pkg::result_t result
);
    localparam int IW = evr_pkg::INT_WIDTH;
    localparam int CW = evr_pkg::COORD_WIDTH;
    localparam int AW = evr_pkg::ANGLE_WIDTH;
    localparam int GB = evr_pkg::GUARD_BITS;

    assign busy = 1'b0;

    // load: sign-extend and add guard fraction bits
    function automatic logic signed [IW-1:0] load(input logic signed [CW-1:0] c);
        return IW'(c) <<< GB;
    endfunction

    // round and saturate to the coordinate range
    function automatic logic signed [CW-1:0] finish(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] t;
        t = (v + (IW'(1) <<< (GB - 1))) >>> GB;
        if (t > IW'((IW'(1) <<< (CW - 1)) - 1))
            return {1'b0, {(CW - 1){1'b1}}};
        else if (t < -(IW'(1) <<< (CW - 1)))
            return {1'b1, {(CW - 1){1'b0}}};
        return CW'(t);
    endfunction

    // X rotation on (y, z); x and remaining angles ride along
    localparam int SX = IW + 2 * AW;
    logic                 vx;
    logic signed [IW-1:0] y1, z1;
    logic [SX-1:0]        sx;

    evr_rotate_pair #(.ROTATION_STEPS(ROTATION_STEPS), .SIDE_WIDTH(SX)) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .in_a      (load(cmd.in_y)),
        .in_b      (load(cmd.in_z)),
        .in_angle  (cmd.angle_x),
        .in_side   ({load(cmd.in_x), cmd.angle_y, cmd.angle_z}),
        .out_valid (vx),
        .out_a     (y1),
        .out_b     (z1),
        .out_side  (sx)
    );

    // Y rotation on (x, z): x' = x*cos - z*sin, z' = x*sin + z*cos
    localparam int SY = IW + AW;
    logic                 vy;
    logic signed [IW-1:0] x2, z2;
    logic [SY-1:0]        sy;

    evr_rotate_pair #(.ROTATION_STEPS(ROTATION_STEPS), .SIDE_WIDTH(SY)) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vx),
        .in_a      (sx[SX-1 -: IW]),
        .in_b      (z1),
        .in_angle  (sx[2*AW-1 -: AW]),
        .in_side   ({y1, sx[AW-1:0]}),
        .out_valid (vy),
        .out_a     (x2),
        .out_b     (z2),
        .out_side  (sy)
    );

    // Z rotation on (x, y); z rides along
    logic                 vz;
    logic signed [IW-1:0] x3, y3;
    logic [IW-1:0]        sz;

    evr_rotate_pair #(.ROTATION_STEPS(ROTATION_STEPS), .SIDE_WIDTH(IW)) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vy),
        .in_a      (x2),
        .in_b      (sy[SY-1 -: IW]),
        .in_angle  (sy[AW-1:0]),
        .in_side   (z2),
        .out_valid (vz),
        .out_a     (x3),
        .out_b     (y3),
        .out_side  (sz)
    );

    // output register
    logic             done_reg;
    evr_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vz;
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_x <= finish(x3);
        result_reg.out_y <= finish(y3);
        result_reg.out_z <= finish(signed'(sz));
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- tb/sv/euler_xyz_vector_rotator_test.sv -----
// euler_xyz_vector_rotator_test: self-checking bench for the Euler XYZ rotator.
// Depends on evr_pkg and euler_xyz_vector_rotator; predicts each result in-line.
`timescale 1ns / 1ps
module euler_xyz_vector_rotator_test;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    evr_pkg::cmd_t    cmd;
    logic             done;
    evr_pkg::result_t result;

    // expected rotated vectors, oldest first
    evr_pkg::result_t rotated_q[$];
    int      mismatches;
    bit      failed;
    // idle odds for the sender, in percent
    int      send_idle_pct;

    euler_xyz_vector_rotator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor shift of a signed 64-bit value
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // multiply by the CORDIC gain, magnitude rounded half up, sign restored
    function automatic longint scale_gain(longint v);
        bit           neg;
        longint unsigned m;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned r;
        neg = v < 0;
        m = neg ? longint'(-v) : v;
        hi = m >> 32;
        lo = m & 64'hFFFF_FFFF;
        r = hi * evr_pkg::GAIN_Q32 + ((lo * evr_pkg::GAIN_Q32 + 64'h8000_0000) >> 32);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // plane rotation (a,b) -> (a*cos - b*sin, a*sin + b*cos)
    function automatic void turn_plane(inout longint a, inout longint b,
                                       input logic [evr_pkg::ANGLE_WIDTH-1:0] ang);
        logic [31:0] u;
        longint      p;
        longint      q;
        longint      ps;
        longint      qs;
        longint      resid;
        u = {ang, {(32-evr_pkg::ANGLE_WIDTH){1'b0}}};
        p = a;
        q = b;
        // second and third quarter: flip the pair and take off a half turn
        if (u[31:30] == 2'd1 || u[31:30] == 2'd2)
        begin
            p = -p;
            q = -q;
            u = u + 32'h8000_0000;
        end
        resid = longint'($signed(u));
        for (int i = 0; i < evr_pkg::ROTATION_STEPS; i++)
        begin
            ps = floor_shift(p, i);
            qs = floor_shift(q, i);
            if (resid >= 0)
            begin
                p = p - qs;
                q = q + ps;
                resid = resid - longint'(evr_pkg::atan_turn(i));
            end
            else
            begin
                p = p + qs;
                q = q - ps;
                resid = resid + longint'(evr_pkg::atan_turn(i));
            end
        end
        a = scale_gain(p);
        b = scale_gain(q);
    endfunction

    // round off guard bits and saturate to Q16.16
    function automatic logic [31:0] clamp_coord(longint v);
        longint t;
        t = (v + (64'sd1 <<< (evr_pkg::GUARD_BITS-1))) >>> evr_pkg::GUARD_BITS;
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t[31:0];
    endfunction

    function automatic evr_pkg::result_t rotate_xyz(evr_pkg::cmd_t c);
        longint  x;
        longint  y;
        longint  z;
        evr_pkg::result_t r;
        x = longint'(c.in_x) <<< evr_pkg::GUARD_BITS;
        y = longint'(c.in_y) <<< evr_pkg::GUARD_BITS;
        z = longint'(c.in_z) <<< evr_pkg::GUARD_BITS;
        turn_plane(y, z, c.angle_x);
        turn_plane(x, z, c.angle_y);
        turn_plane(x, y, c.angle_z);
        r.out_x = clamp_coord(x);
        r.out_y = clamp_coord(y);
        r.out_z = clamp_coord(z);
        return r;
    endfunction

    // offer one beat, holding start until it is taken; random idle cycles first
    task automatic send_vector(evr_pkg::cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rotated_q.push_back(rotate_xyz(c));
    endtask

    // drop start once the stream has ended
    task automatic park_sender();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0004_0000) - 32'h0002_0000; // near origin
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(4))
            0: return 16'(16'h4000 * $urandom_range(3));  // quarter turns
            1: return {2'($urandom_range(3)), 14'h0} + 16'($urandom_range(2))
                      - 16'd1; // near seams
            default: return 16'($urandom());
        endcase
    endfunction

    // 24 vectors mixing field extremes and quarter-turn seams
    task automatic test_directed();
        logic [31:0] ext[4];
        logic [15:0] ang[6];
        evr_pkg::cmd_t c;
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0};
        ang = '{16'h0, 16'h3FFF, 16'h4000, 16'hBFFF, 16'hC000, 16'hFFFF};
        for (int k = 0; k < 24; k++)
        begin
            c.in_x    = ext[k % 4];
            c.in_y    = ext[(k / 4) % 4];
            c.in_z    = ext[(k + 1) % 4];
            c.angle_x = ang[k % 6];
            c.angle_y = ang[(k / 2) % 6];
            c.angle_z = ang[(k / 4) % 6];
            send_vector(c);
        end
        park_sender();
    endtask

    task automatic test_random(int n, int idle_pct);
        evr_pkg::cmd_t c;
        send_idle_pct = idle_pct;
        for (int k = 0; k < n; k++)
        begin
            c.in_x    = rand_coord();
            c.in_y    = rand_coord();
            c.in_z    = rand_coord();
            c.angle_x = rand_angle();
            c.angle_y = rand_angle();
            c.angle_z = rand_angle();
            send_vector(c);
        end
        park_sender();
        send_idle_pct = 0;
    endtask

    // result checker: each done beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rotated_q.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", result);
            end
            else
            begin
                evr_pkg::result_t want;
                want = rotated_q.pop_front();
                if (want.out_x !== result.out_x || want.out_y !== result.out_y
                    || want.out_z !== result.out_z)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: want x=%h y=%h z=%h got x=%h y=%h z=%h",
                                 want.out_x, want.out_y, want.out_z,
                                 result.out_x, result.out_y, result.out_z);
                end
            end
        end
    end

    initial
    begin
        // watchdog: fail the run if the stream has not drained by then
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatches = 0;
        failed = 1'b0;
        send_idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        // sender idles 33%, then 65%, then never
        test_random(460, 33);
        test_random(460, 65);
        test_random(460, 0);
        guard = 0;
        while (rotated_q.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        // wait out the pipeline and watch for stray result beats
        repeat (80) @(posedge clk);
        if (!failed && rotated_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
